// ===== rtl/uwl_pkg.sv =====
// Package with shared types and constants of the UID whitelist table.
`default_nettype none
package uwl_pkg;
  localparam int ENTRIES = 128;
  localparam int TABLES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [3:0] {
    OP_SEARCH = 4'd0, OP_ADD = 4'd1, OP_DELETE = 4'd2, OP_READ = 4'd3,
    OP_NEXT = 4'd4, OP_SET = 4'd5, OP_CLEAR = 4'd6, OP_TEST = 4'd7,
    OP_CLRTAB = 4'd8, OP_REWIND = 4'd9
  } opcode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_ADD_FREE, S_ADD_WAIT, S_WRAP, S_NEXT_WAIT,
    S_SLOT_RD, S_SLOT_WAIT, S_CLR, S_DONE, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item
    logic ptr_clr;   // pointer to zero
    logic ptr_cur;   // pointer to scan cursor
    logic ptr_slot;  // pointer to the item's slot
    logic ptr_inc;   // step the pointer
    logic rd;        // read both stores at the pointer
    logic wr_mark;   // write mark word at the pointer
    logic wr_uid;    // write uid at the pointer
    logic clr_bit;   // clear selected table bit during a sweep
    logic fin;       // form result from the last read
    logic miss;      // form a miss result
    logic wrap_mark; // remember wrap start
  } uwl_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic [3:0] op;
    logic slot_ok;
    logic table_ok;
    logic ptr_last;    // pointer is at ENTRIES-1
    logic ptr_at_end;  // pointer reached the wrap limit
    logic uid_hit;     // last read: in use and UID matches
    logic used;        // last read: in use
    logic tbl_bit;     // last read: selected table bit
    logic cur_zero;    // scan cursor at zero or ENTRIES
    logic sweeping;    // clearing pass after reset still running
  } uwl_sts_t;
endpackage
`default_nettype wire

// ===== rtl/uwl_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module uwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/uwl_datapath.sv =====
// Datapath of the UID whitelist table: stores, pointer, cursor, count and result.
`default_nettype none
module uwl_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire uwl_pkg::uwl_cmd_t         cmd,
  output uwl_pkg::uwl_sts_t              sts,
  input  wire logic [3:0]                in_opcode,
  input  wire logic [31:0]               in_card_uid,
  input  wire logic [6:0]                in_slot_index,
  input  wire logic [3:0]                in_table_sel,
  output logic [1:0]                     res_status,
  output logic [6:0]                     res_found_index,
  output logic [31:0]                    res_entry_uid,
  output logic                           res_mark_bit,
  output logic [7:0]                     res_entry_count
);
  localparam int IW = uwl_pkg::IDX_W;
  localparam int CW = uwl_pkg::CNT_W;

  logic [3:0] op_r;
  logic [31:0] uid_r;
  logic [6:0] slot_r;
  logic [3:0] tbl_r;
  logic [IW:0] ptr_r, ptr_nxt, lim_r;
  logic [IW:0] cur_r;
  logic [CW-1:0] cnt_r;
  logic [uwl_pkg::TABLES-1:0] mark_rd, mark_wd;
  logic [31:0] uid_rd;
  logic [IW-1:0] addr_r;  // address of the last read
  logic [IW-1:0] addr;
  logic [15:0] tbl_1h;
  logic [1:0] st_r;
  logic [6:0] fi_r;
  logic [31:0] eu_r;
  logic mb_r;
  logic sweep_r;  // clearing pass after reset

  assign addr = ptr_r[IW-1:0];
  assign tbl_1h = 16'd1 << tbl_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) ptr_nxt = '0;
    else if (cmd.ptr_cur) ptr_nxt = (cur_r == (IW+1)'(uwl_pkg::ENTRIES)) ? '0 : cur_r;
    else if (cmd.ptr_slot) ptr_nxt = (IW+1)'(slot_r);
    else if (cmd.ptr_inc) ptr_nxt = ptr_r + 1'b1;
  end

  always_comb begin
    mark_wd = mark_rd;
    if (cmd.clr_bit) mark_wd = mark_rd & ~uwl_pkg::TABLES'(tbl_1h);
    else if (op_r == uwl_pkg::OP_ADD) mark_wd = mark_rd | uwl_pkg::TABLES'(1);
    else if (op_r == uwl_pkg::OP_DELETE) mark_wd = mark_rd & ~uwl_pkg::TABLES'(1);
    else if (op_r == uwl_pkg::OP_SET) mark_wd = mark_rd | uwl_pkg::TABLES'(tbl_1h);
    else if (op_r == uwl_pkg::OP_CLEAR) mark_wd = mark_rd & ~uwl_pkg::TABLES'(tbl_1h);
    if (sweep_r) mark_wd = '0;
  end

  uwl_ram #(.WIDTH(uwl_pkg::TABLES), .DEPTH(uwl_pkg::ENTRIES)) u_mark (
    .clk(clk), .we(cmd.wr_mark || sweep_r), .addr(addr), .wdata(mark_wd), .rdata(mark_rd)
  );
  uwl_ram #(.WIDTH(32), .DEPTH(uwl_pkg::ENTRIES)) u_uid (
    .clk(clk), .we(cmd.wr_uid), .addr(addr), .wdata(uid_r), .rdata(uid_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cur_r <= '0;
      cnt_r <= '0;
      sweep_r <= 1'b1;
      lim_r <= '0;
    end else begin
      if (sweep_r) begin
        if (ptr_r == (IW+1)'(uwl_pkg::ENTRIES - 1)) begin
          sweep_r <= 1'b0;
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end else begin
        ptr_r <= ptr_nxt;
      end
      if (cmd.wrap_mark) lim_r <= (cur_r == (IW+1)'(uwl_pkg::ENTRIES)) ? '0 : cur_r;
      if (cmd.fin && op_r == uwl_pkg::OP_NEXT) cur_r <= {1'b0, addr_r} + 1'b1;
      if (cmd.load && in_opcode == uwl_pkg::OP_REWIND) cur_r <= '0;
      if (cmd.wr_mark && !cmd.clr_bit) begin
        if ((op_r == uwl_pkg::OP_ADD || (op_r == uwl_pkg::OP_SET && tbl_r == 4'd0))
            && cnt_r != CW'(uwl_pkg::ENTRIES))
          cnt_r <= cnt_r + 1'b1;
        if ((op_r == uwl_pkg::OP_DELETE || (op_r == uwl_pkg::OP_CLEAR && tbl_r == 4'd0))
            && cnt_r != '0)
          cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_opcode;
      uid_r <= in_card_uid;
      slot_r <= in_slot_index;
      tbl_r <= in_table_sel;
      st_r <= (in_opcode == uwl_pkg::OP_REWIND) ? uwl_pkg::ST_OK : uwl_pkg::ST_MISS;
      fi_r <= '0;
      eu_r <= '0;
      mb_r <= 1'b0;
    end else if (cmd.fin) begin
      st_r <= (op_r == uwl_pkg::OP_ADD && sts.uid_hit) ? uwl_pkg::ST_DUP : uwl_pkg::ST_OK;
      fi_r <= 7'(addr_r);
      mb_r <= (op_r == uwl_pkg::OP_TEST) ? sts.tbl_bit : 1'b0;
      // In-use after this operation.
      if (op_r == uwl_pkg::OP_ADD) eu_r <= sts.used ? uid_rd : uid_r;
      else if (op_r == uwl_pkg::OP_SET && tbl_r == 4'd0) eu_r <= uid_rd;
      else if (op_r == uwl_pkg::OP_DELETE || (op_r == uwl_pkg::OP_CLEAR && tbl_r == 4'd0))
        eu_r <= '0;
      else eu_r <= sts.used ? uid_rd : '0;
    end else if (cmd.miss) begin
      st_r <= (op_r == uwl_pkg::OP_CLRTAB && sts.table_ok) ? uwl_pkg::ST_OK : uwl_pkg::ST_MISS;
      fi_r <= '0;
      eu_r <= '0;
      mb_r <= 1'b0;
    end
    if (cmd.rd) addr_r <= addr;
  end

  assign sts.op = op_r;
  assign sts.slot_ok = 32'(slot_r) < uwl_pkg::ENTRIES;
  assign sts.table_ok = 32'(tbl_r) < uwl_pkg::TABLES;
  assign sts.ptr_last = ptr_r == (IW+1)'(uwl_pkg::ENTRIES - 1);
  assign sts.ptr_at_end = ptr_r == lim_r;
  assign sts.used = mark_rd[0];
  assign sts.uid_hit = mark_rd[0] && uid_rd == uid_r;
  assign sts.tbl_bit = mark_rd[tbl_r];
  assign sts.cur_zero = cur_r == '0 || cur_r == (IW+1)'(uwl_pkg::ENTRIES);
  assign sts.sweeping = sweep_r;

  assign res_status = st_r;
  assign res_found_index = fi_r;
  assign res_entry_uid = eu_r;
  assign res_mark_bit = mb_r;
  assign res_entry_count = 8'(cnt_r);
endmodule
`default_nettype wire

// ===== rtl/uwl_ctrl.sv =====
// Controller state machine of the UID whitelist table.
`default_nettype none
module uwl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire logic              sweep_busy,
  input  wire uwl_pkg::uwl_sts_t sts,
  output uwl_pkg::uwl_cmd_t      cmd
);
  uwl_pkg::state_t state_r, state_nxt;
  logic wrapped_r, wrapped_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uwl_pkg::S_IDLE;
      wrapped_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wrapped_nxt = wrapped_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      uwl_pkg::S_IDLE: begin
        in_stall = sweep_busy;
        if (in_valid && !sweep_busy) begin
          cmd.load = 1'b1;
          state_nxt = uwl_pkg::S_DONE;
        end
      end
      uwl_pkg::S_DONE: begin
        // Dispatch on the captured opcode.
        case (sts.op)
          uwl_pkg::OP_SEARCH, uwl_pkg::OP_ADD, uwl_pkg::OP_DELETE: begin
            cmd.ptr_clr = 1'b1;
            state_nxt = uwl_pkg::S_SCAN;
          end
          uwl_pkg::OP_READ: begin
            cmd.ptr_slot = 1'b1;
            if (sts.slot_ok) state_nxt = uwl_pkg::S_SLOT_RD;
            else begin cmd.miss = 1'b1; state_nxt = uwl_pkg::S_OUT; end
          end
          uwl_pkg::OP_SET, uwl_pkg::OP_CLEAR, uwl_pkg::OP_TEST: begin
            cmd.ptr_slot = 1'b1;
            if (sts.slot_ok && sts.table_ok) state_nxt = uwl_pkg::S_SLOT_RD;
            else begin cmd.miss = 1'b1; state_nxt = uwl_pkg::S_OUT; end
          end
          uwl_pkg::OP_NEXT: begin
            cmd.ptr_cur = 1'b1;
            cmd.wrap_mark = 1'b1;
            wrapped_nxt = 1'b0;
            if (sts.table_ok) state_nxt = uwl_pkg::S_WRAP;
            else begin cmd.miss = 1'b1; state_nxt = uwl_pkg::S_OUT; end
          end
          uwl_pkg::OP_CLRTAB: begin
            cmd.ptr_clr = 1'b1;
            cmd.miss = 1'b1;
            state_nxt = sts.table_ok ? uwl_pkg::S_CLR : uwl_pkg::S_OUT;
          end
          default: state_nxt = uwl_pkg::S_OUT;
        endcase
      end
      uwl_pkg::S_SCAN: begin
        cmd.rd = 1'b1;
        state_nxt = uwl_pkg::S_SCAN_WAIT;
      end
      uwl_pkg::S_SCAN_WAIT: begin
        if (sts.uid_hit) begin
          cmd.fin = 1'b1;
          if (sts.op == uwl_pkg::OP_DELETE) begin
            cmd.ptr_slot = 1'b0;
            cmd.wr_mark = 1'b1;
          end
          state_nxt = uwl_pkg::S_OUT;
        end else if (sts.ptr_last) begin
          if (sts.op == uwl_pkg::OP_ADD) begin
            cmd.ptr_clr = 1'b1;
            state_nxt = uwl_pkg::S_ADD_FREE;
          end else begin
            cmd.miss = 1'b1;
            state_nxt = uwl_pkg::S_OUT;
          end
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt = uwl_pkg::S_SCAN;
        end
      end
      uwl_pkg::S_ADD_FREE: begin
        cmd.rd = 1'b1;
        state_nxt = uwl_pkg::S_ADD_WAIT;
      end
      uwl_pkg::S_ADD_WAIT: begin
        if (!sts.used) begin
          cmd.fin = 1'b1;
          cmd.wr_mark = 1'b1;
          cmd.wr_uid = 1'b1;
          state_nxt = uwl_pkg::S_OUT;
        end else if (sts.ptr_last) begin
          cmd.miss = 1'b1;
          state_nxt = uwl_pkg::S_OUT;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt = uwl_pkg::S_ADD_FREE;
        end
      end
      uwl_pkg::S_WRAP: begin
        cmd.rd = 1'b1;
        state_nxt = uwl_pkg::S_NEXT_WAIT;
      end
      uwl_pkg::S_NEXT_WAIT: begin
        if (sts.tbl_bit) begin
          cmd.fin = 1'b1;
          state_nxt = uwl_pkg::S_OUT;
        end else begin
          if (sts.ptr_last) cmd.ptr_clr = 1'b1;
          else cmd.ptr_inc = 1'b1;
          wrapped_nxt = 1'b1;
          state_nxt = uwl_pkg::S_WRAP;
          // Stop once the pointer comes round to where it began.
          if (sts.ptr_last && sts.cur_zero) begin
            cmd.miss = 1'b1;
            state_nxt = uwl_pkg::S_OUT;
          end
        end
      end
      uwl_pkg::S_SLOT_RD: begin
        cmd.rd = 1'b1;
        state_nxt = uwl_pkg::S_SLOT_WAIT;
      end
      uwl_pkg::S_SLOT_WAIT: begin
        if (sts.op == uwl_pkg::OP_READ && !sts.used) cmd.miss = 1'b1;
        else cmd.fin = 1'b1;
        if (sts.op == uwl_pkg::OP_SET || sts.op == uwl_pkg::OP_CLEAR) cmd.wr_mark = 1'b1;
        state_nxt = uwl_pkg::S_OUT;
      end
      uwl_pkg::S_CLR: begin
        // Read one slot, write it back with the table bit cleared next cycle.
        cmd.rd = 1'b1;
        state_nxt = uwl_pkg::S_CLR;
        if (wrapped_r) begin
          cmd.rd = 1'b0;
          cmd.wr_mark = 1'b1;
          cmd.clr_bit = 1'b1;
          if (sts.ptr_last) state_nxt = uwl_pkg::S_OUT;
          else cmd.ptr_inc = 1'b1;
        end
        wrapped_nxt = !wrapped_r;
      end
      uwl_pkg::S_OUT: begin
        out_valid = 1'b1;
        wrapped_nxt = 1'b0;
        if (!out_stall) state_nxt = uwl_pkg::S_IDLE;
      end
      default: state_nxt = uwl_pkg::S_IDLE;
    endcase
    // Wrap stop for the next-marked scan: back at the start position.
    if (state_r == uwl_pkg::S_WRAP && wrapped_r && sts.ptr_at_end) begin
      cmd.rd = 1'b0;
      cmd.miss = 1'b1;
      state_nxt = uwl_pkg::S_OUT;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/uid_whitelist_table.sv =====
// Top level of the UID whitelist table.
`default_nettype none
// UID whitelist table: 128 slots of a 32-bit card UID and a 16-bit mark word.
// An item enters on in_valid when in_stall is low and carries an opcode, a
// UID, a slot index and a table select. Exactly one result item leaves on
// out_valid, held until out_stall is low.
// Items are taken one at a time. Search, add, delete and next-marked walk the
// slot memory one slot at a time (registered memory read, then compare), and
// add walks it a second time when it has to look for a free slot; clear table
// sweeps all slots, reading each slot and then writing it back.
// After reset the block runs a clearing pass over the mark memory with in_stall
// high. Count and cursor reset to zero.
// While out_stall is high the result holds and no new item is taken.
module uid_whitelist_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [31:0] in_card_uid,
  input  wire logic [6:0]  in_slot_index,
  input  wire logic [3:0]  in_table_sel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [6:0]       out_found_index,
  output logic [31:0]      out_entry_uid,
  output logic             out_mark_bit,
  output logic [7:0]       out_entry_count
);
  uwl_pkg::uwl_cmd_t cmd;
  uwl_pkg::uwl_sts_t sts;

  // The input waits until the clearing pass after reset has finished.
  uwl_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sweep_busy(sts.sweeping),
    .sts(sts), .cmd(cmd)
  );

  uwl_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_opcode(in_opcode), .in_card_uid(in_card_uid),
    .in_slot_index(in_slot_index), .in_table_sel(in_table_sel),
    .res_status(out_status), .res_found_index(out_found_index),
    .res_entry_uid(out_entry_uid), .res_mark_bit(out_mark_bit),
    .res_entry_count(out_entry_count)
  );

  // A result held by out_stall stays valid with its status unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  // No input is taken while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken during output");
  // The count never exceeds the slot count.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(out_entry_count) <= uwl_pkg::ENTRIES)
    else $error("entry count overflow");
endmodule
`default_nettype wire

// ===== sim/uwl_checker.sv =====
// Checker that predicts and compares the results of the UID whitelist table.
module uwl_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [31:0] in_card_uid,
  input  logic [6:0]  in_slot_index,
  input  logic [3:0]  in_table_sel,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [6:0]  out_found_index,
  input  logic [31:0] out_entry_uid,
  input  logic        out_mark_bit,
  input  logic [7:0]  out_entry_count,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  index;
    logic [31:0] uid;
    logic        mark;
    logic [7:0]  count;
  } answer_t;

  logic [31:0]                card_mem [uwl_pkg::ENTRIES];
  logic [uwl_pkg::TABLES-1:0] marks [uwl_pkg::ENTRIES];
  int                         used_cnt;
  int                         cursor;
  answer_t                    pending_answers[$];

  // Fill index and UID of a result from a slot; UID only if the slot is in use.
  function automatic void show_slot(int s, ref answer_t a);
    a.index = s[6:0];
    a.uid   = marks[s][0] ? card_mem[s] : 32'd0;
  endfunction

  function automatic int lookup_card(logic [31:0] uid);
    for (int i = 0; i < uwl_pkg::ENTRIES; i++)
      if (marks[i][0] && card_mem[i] == uid) return i;
    return -1;
  endfunction

  function automatic answer_t apply_command(logic [3:0] op, logic [31:0] uid,
                                            logic [6:0] slot, logic [3:0] tbl);
    answer_t a;
    int p;
    int s;
    int t;
    s = slot;
    t = tbl;
    a = '0;
    a.status = uwl_pkg::ST_MISS;
    case (op)
      uwl_pkg::OP_SEARCH: begin
        p = lookup_card(uid);
        if (p >= 0) begin
          a.status = uwl_pkg::ST_OK;
          show_slot(p, a);
        end
      end
      uwl_pkg::OP_ADD: begin
        p = lookup_card(uid);
        if (p >= 0) begin
          a.status = uwl_pkg::ST_DUP;
          show_slot(p, a);
        end else begin
          for (int i = 0; i < uwl_pkg::ENTRIES; i++)
            if (!marks[i][0]) begin
              p = i;
              break;
            end
          if (p >= 0) begin
            card_mem[p] = uid;
            marks[p][0] = 1'b1;
            if (used_cnt < uwl_pkg::ENTRIES) used_cnt++;
            a.status = uwl_pkg::ST_OK;
            show_slot(p, a);
          end
        end
      end
      uwl_pkg::OP_DELETE: begin
        p = lookup_card(uid);
        if (p >= 0) begin
          marks[p][0] = 1'b0;
          if (used_cnt > 0) used_cnt--;
          a.status = uwl_pkg::ST_OK;
          show_slot(p, a);
        end
      end
      uwl_pkg::OP_READ: begin
        if (s < uwl_pkg::ENTRIES && marks[s][0]) begin
          a.status = uwl_pkg::ST_OK;
          show_slot(s, a);
        end
      end
      uwl_pkg::OP_NEXT: begin
        if (t < uwl_pkg::TABLES) begin
          p = -1;
          for (int i = cursor; i < uwl_pkg::ENTRIES; i++)
            if (marks[i][t]) begin
              p = i;
              break;
            end
          if (p < 0)
            for (int i = 0; i < cursor && i < uwl_pkg::ENTRIES; i++)
              if (marks[i][t]) begin
                p = i;
                break;
              end
          if (p >= 0) begin
            cursor = p + 1;
            a.status = uwl_pkg::ST_OK;
            show_slot(p, a);
          end
        end
      end
      uwl_pkg::OP_SET, uwl_pkg::OP_CLEAR: begin
        if (s < uwl_pkg::ENTRIES && t < uwl_pkg::TABLES) begin
          marks[s][t] = (op == uwl_pkg::OP_SET);
          if (t == 0) begin
            if (op == uwl_pkg::OP_SET && used_cnt < uwl_pkg::ENTRIES) used_cnt++;
            if (op == uwl_pkg::OP_CLEAR && used_cnt > 0) used_cnt--;
          end
          a.status = uwl_pkg::ST_OK;
          show_slot(s, a);
        end
      end
      uwl_pkg::OP_TEST: begin
        if (s < uwl_pkg::ENTRIES && t < uwl_pkg::TABLES) begin
          a.mark = marks[s][t];
          a.status = uwl_pkg::ST_OK;
          show_slot(s, a);
        end
      end
      uwl_pkg::OP_CLRTAB: begin
        if (t < uwl_pkg::TABLES) begin
          for (int i = 0; i < uwl_pkg::ENTRIES; i++) marks[i][t] = 1'b0;
          a.status = uwl_pkg::ST_OK;
        end
      end
      uwl_pkg::OP_REWIND: begin
        cursor = 0;
        a.status = uwl_pkg::ST_OK;
      end
      default: ;
    endcase
    a.count = used_cnt[7:0];
    return a;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      for (int i = 0; i < uwl_pkg::ENTRIES; i++) begin
        marks[i]    = '0;
        card_mem[i] = '0;
      end
      used_cnt = 0;
      cursor   = 0;
      errors   = 0;
      pending_answers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: result with none expected, actual status %0d index %0d",
                   $time, out_status, out_found_index);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          report_field("status", 32'(want.status), 32'(out_status));
          report_field("found_index", 32'(want.index), 32'(out_found_index));
          report_field("entry_uid", want.uid, out_entry_uid);
          report_field("mark_bit", 32'(want.mark), 32'(out_mark_bit));
          report_field("entry_count", 32'(want.count), 32'(out_entry_count));
        end
      end
      if (in_valid && !in_stall)
        pending_answers.push_back(apply_command(in_opcode, in_card_uid,
                                                in_slot_index, in_table_sel));
    end
  end
endmodule

// ===== sim/tb.sv =====
// Testbench top for the UID whitelist table: stimulus, handshakes and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_opcode;
  logic [31:0] in_card_uid;
  logic [6:0]  in_slot_index;
  logic [3:0]  in_table_sel;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [6:0]  out_found_index;
  logic [31:0] out_entry_uid;
  logic        out_mark_bit;
  logic [7:0]  out_entry_count;
  int          errors;

  // Outstanding results, kept from the port handshakes alone.
  int          in_flight;
  int          idle_cycles;
  bit          no_gaps;
  // UIDs that the fill phase wrote, reused so that searches and deletes hit.
  logic [31:0] known_cards [uwl_pkg::ENTRIES];
  // Once every slot has had a UID written, a table-0 set may address any slot.
  bit          all_written;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 950;

  uid_whitelist_table dut (.*);

  uwl_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Offer one item and hold it until the block takes it. The valid is lowered
  // only when a gap is wanted, so it is never lowered and raised in one step.
  task automatic send_item(logic [3:0] op, logic [31:0] uid, logic [6:0] slot,
                           logic [3:0] tbl);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_card_uid   <= uid;
    in_slot_index <= slot;
    in_table_sel  <= tbl;
    do @(posedge clk); while (in_stall);
  endtask

  // A random item. A table-0 set is aimed only at slots that already hold a
  // written UID, so that no unwritten UID is ever read back.
  task automatic send_random();
    logic [3:0]  op;
    logic [31:0] uid;
    logic [6:0]  slot;
    logic [3:0]  tbl;
    int          r;
    r = $urandom_range(99);
    if (r < 18)      op = uwl_pkg::OP_SEARCH;
    else if (r < 32) op = uwl_pkg::OP_ADD;
    else if (r < 42) op = uwl_pkg::OP_DELETE;
    else if (r < 50) op = uwl_pkg::OP_READ;
    else if (r < 62) op = uwl_pkg::OP_NEXT;
    else if (r < 72) op = uwl_pkg::OP_SET;
    else if (r < 81) op = uwl_pkg::OP_CLEAR;
    else if (r < 90) op = uwl_pkg::OP_TEST;
    else if (r < 93) op = uwl_pkg::OP_CLRTAB;
    else if (r < 96) op = uwl_pkg::OP_REWIND;
    else             op = 4'($urandom_range(15, 10));
    uid  = ($urandom_range(99) < 70) ? known_cards[$urandom_range(uwl_pkg::ENTRIES - 1)]
                                     : $urandom;
    slot = 7'($urandom_range(uwl_pkg::ENTRIES - 1));
    tbl  = ($urandom_range(99) < 35) ? 4'd0 : 4'($urandom_range(uwl_pkg::TABLES - 1));
    if (op == uwl_pkg::OP_SET && tbl == 4'd0 && !all_written) tbl = 4'd1;
    // Clearing table 0 empties the list too often; keep it rare.
    if (op == uwl_pkg::OP_CLRTAB && tbl == 4'd0 && $urandom_range(3) != 0) tbl = 4'd2;
    send_item(op, uid, slot, tbl);
  endtask

  // Receiver: random stalls with calm stretches, and one long hold-off while
  // the sender keeps offering, so the block backs up into its input.
  initial begin
    int cycles;
    int n;
    bit held;
    out_stall = 1'b0;
    cycles = 0;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && cycles > 4000) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (500) @(posedge clk);
        cycles += 500;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : pick_gap();
      out_stall <= (n > 0);
      repeat (n) @(posedge clk);
      cycles += n;
      out_stall <= 1'b0;
      n = $urandom_range(8, 1);
      if ($urandom_range(7) == 0) n = $urandom_range(300, 60);
      repeat (n) @(posedge clk);
      cycles += n;
    end
  end

  // Track outstanding results and watch for a stuck block.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_flight   <= 0;
      idle_cycles <= 0;
    end else begin
      in_flight <= in_flight + int'(in_valid && !in_stall) - int'(out_valid && !out_stall);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] card_a;
    logic [31:0] card_b;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_card_uid   = '0;
    in_slot_index = '0;
    in_table_sel  = '0;
    no_gaps       = 1'b0;
    all_written   = 1'b0;
    for (int i = 0; i < uwl_pkg::ENTRIES; i++) known_cards[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Slots 0 and 1 receive written UIDs first.
    card_a = 32'hFFFF_FFFF;
    card_b = 32'h0000_0000;
    send_item(uwl_pkg::OP_SEARCH, card_a, 7'd0, 4'd0);     // empty table: miss
    send_item(uwl_pkg::OP_DELETE, card_a, 7'd0, 4'd0);     // delete of an absent UID
    send_item(uwl_pkg::OP_NEXT, 32'd0, 7'd0, 4'd0);        // scan of an empty table
    send_item(uwl_pkg::OP_ADD, card_a, 7'd0, 4'd0);
    send_item(uwl_pkg::OP_ADD, card_b, 7'd0, 4'd0);
    send_item(uwl_pkg::OP_ADD, card_a, 7'd0, 4'd0);        // already present
    send_item(uwl_pkg::OP_SEARCH, card_b, 7'd0, 4'd0);
    send_item(uwl_pkg::OP_READ, 32'd0, 7'd1, 4'd0);
    send_item(uwl_pkg::OP_READ, 32'd0, 7'd127, 4'd0);      // slot not in use
    send_item(uwl_pkg::OP_DELETE, card_a, 7'd0, 4'd0);     // entry_uid reads back zero
    send_item(uwl_pkg::OP_SET, 32'd0, 7'd0, 4'd0);         // back in use, count moves
    send_item(uwl_pkg::OP_SET, 32'd0, 7'd0, 4'd0);         // repeated set still counts
    send_item(uwl_pkg::OP_CLEAR, 32'd0, 7'd1, 4'd0);
    send_item(uwl_pkg::OP_CLEAR, 32'd0, 7'd1, 4'd0);       // repeated clear
    send_item(uwl_pkg::OP_CLEAR, 32'd0, 7'd1, 4'd0);       // count reaches zero
    send_item(uwl_pkg::OP_SET, 32'd0, 7'd127, 4'd15);
    send_item(uwl_pkg::OP_SET, 32'd0, 7'd5, 4'd15);
    send_item(uwl_pkg::OP_TEST, 32'd0, 7'd127, 4'd15);
    send_item(uwl_pkg::OP_NEXT, 32'd0, 7'd0, 4'd15);       // hits slot 5
    send_item(uwl_pkg::OP_NEXT, 32'd0, 7'd0, 4'd15);       // hits slot 127, cursor at end
    send_item(uwl_pkg::OP_NEXT, 32'd0, 7'd0, 4'd15);       // wraps to slot 5
    send_item(uwl_pkg::OP_REWIND, 32'd0, 7'd0, 4'd0);
    send_item(uwl_pkg::OP_CLRTAB, 32'd0, 7'd0, 4'd15);
    send_item(4'd15, 32'hA5A5_5A5A, 7'd85, 4'd10);         // unused opcode
    send_item(uwl_pkg::OP_CLRTAB, 32'd0, 7'd0, 4'd0);      // count stays as it was

    // Fill every slot with distinct random UIDs, then run into a full table.
    for (int i = 0; i < uwl_pkg::ENTRIES + 2; i++) begin
      card_a = {16'($urandom_range(16'hFFFF)), 8'($urandom), 8'(i)};
      if (i < uwl_pkg::ENTRIES) known_cards[i] = card_a;
      send_item(uwl_pkg::OP_ADD, card_a, 7'd0, 4'd0);
    end
    all_written = 1'b1;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_gaps = (n >= 500 && n < 600);
      send_random();
    end
    in_valid <= 1'b0;

    while (in_flight != 0) @(posedge clk);
    repeat (4 * uwl_pkg::ENTRIES + 20) @(posedge clk);
    if (errors == 0 && in_flight == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/uwl_pkg.sv
rtl/uwl_ram.sv
rtl/uwl_datapath.sv
rtl/uwl_ctrl.sv
rtl/uid_whitelist_table.sv
sim/uwl_checker.sv
sim/tb.sv
